// ===== src/trdf_pkg.sv =====
package trdf_pkg;

   localparam logic [7:0] ST_RELEASE = 8'h80;
   localparam logic [7:0] ST_ONE     = 8'h81;
   localparam logic [7:0] ST_TWO     = 8'h82;
   localparam logic [7:0] GS_OUT     = 8'h48;
   localparam logic [7:0] GS_IN      = 8'h49;
   localparam logic [7:0] LVL_TOUCH  = 8'hff;
   localparam logic [7:0] LVL_NONE   = 8'h00;

   localparam int COORD_W = 10;
   localparam int STEP_W  = 7;
   localparam int CSR_W   = 10;

   localparam logic CSR_MOVE_THRESHOLD = 1'b0;
   localparam logic CSR_PINCH_STEP     = 1'b1;

   localparam logic [COORD_W-1:0] THRESHOLD_RESET = 10'd1;
   localparam logic [STEP_W-1:0]  STEP_RESET      = 7'd10;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type         move_threshold;
      logic [STEP_W-1:0] pinch_step;
   } cfg_type;

   typedef struct packed {
      logic [7:0] status_code;
      coord_type  first_x;
      coord_type  first_y;
      coord_type  second_x;
      coord_type  second_y;
      logic [7:0] gesture_code;
   } item_type;

   typedef struct packed {
      logic              report_kept;
      logic              first_valid;
      logic              second_valid;
      logic [7:0]        touch_level;
      coord_type         out_first_x;
      coord_type         out_first_y;
      coord_type         out_second_x;
      coord_type         out_second_y;
      logic signed [7:0] pinch_amount;
      logic              ack_needed;
   } result_type;

endpackage

// ===== src/trdf_channels.sv =====
interface trdf_req_if;
   logic                valid;
   logic                ready;
   logic [7:0]          status_code;
   trdf_pkg::coord_type first_x;
   trdf_pkg::coord_type first_y;
   trdf_pkg::coord_type second_x;
   trdf_pkg::coord_type second_y;
   logic [7:0]          gesture_code;

   modport source(output valid, status_code, first_x, first_y, second_x, second_y,
                  gesture_code, input ready);
   modport sink(input valid, status_code, first_x, first_y, second_x, second_y,
                gesture_code, output ready);
endinterface

interface trdf_rsp_if;
   logic                valid;
   logic                ready;
   logic                report_kept;
   logic                first_valid;
   logic                second_valid;
   logic [7:0]          touch_level;
   trdf_pkg::coord_type out_first_x;
   trdf_pkg::coord_type out_first_y;
   trdf_pkg::coord_type out_second_x;
   trdf_pkg::coord_type out_second_y;
   logic signed [7:0]   pinch_amount;
   logic                ack_needed;

   modport source(output valid, report_kept, first_valid, second_valid, touch_level,
                  out_first_x, out_first_y, out_second_x, out_second_y, pinch_amount,
                  ack_needed, input ready);
   modport sink(input valid, report_kept, first_valid, second_valid, touch_level,
                out_first_x, out_first_y, out_second_x, out_second_y, pinch_amount,
                ack_needed, output ready);
endinterface

// ===== src/trdf_csr.sv =====
module trdf_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [trdf_pkg::CSR_W-1:0]   csr_write_data,
   output trdf_pkg::cfg_type            cfg
);

   trdf_pkg::cfg_type cfg_ff;
   trdf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            trdf_pkg::CSR_MOVE_THRESHOLD:
               cfg_in.move_threshold = csr_write_data[trdf_pkg::COORD_W-1:0];
            trdf_pkg::CSR_PINCH_STEP:
               cfg_in.pinch_step = csr_write_data[trdf_pkg::STEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_threshold <= trdf_pkg::THRESHOLD_RESET;
         cfg_ff.pinch_step     <= trdf_pkg::STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/trdf_filter.sv =====
module trdf_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  trdf_pkg::cfg_type     cfg,
   input  trdf_pkg::item_type    item,
   input  logic                  advance,
   output trdf_pkg::result_type  result
);

   trdf_pkg::coord_type ref_horizontal_ff [2];
   trdf_pkg::coord_type ref_vertical_ff   [2];
   trdf_pkg::coord_type ref_horizontal_in [2];
   trdf_pkg::coord_type ref_vertical_in   [2];

   logic release_hit;
   logic two_hit;
   logic one_hit;
   logic still0;
   logic still1;
   logic kept;
   logic [trdf_pkg::STEP_W:0] step_ext;

   function automatic logic near(input trdf_pkg::coord_type a, input trdf_pkg::coord_type b,
                                 input trdf_pkg::coord_type thr);
      trdf_pkg::coord_type diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff < thr;
   endfunction

   assign release_hit = (item.status_code == trdf_pkg::ST_RELEASE);
   assign two_hit     = (item.status_code == trdf_pkg::ST_TWO);
   assign one_hit     = (item.status_code == trdf_pkg::ST_ONE);

   assign still0 = !release_hit
                   && near(ref_horizontal_ff[0], item.first_x, cfg.move_threshold)
                   && near(ref_vertical_ff[0], item.first_y, cfg.move_threshold);
   assign still1 = !two_hit
                   || (near(ref_horizontal_ff[1], item.second_x, cfg.move_threshold)
                       && near(ref_vertical_ff[1], item.second_y, cfg.move_threshold));
   assign kept = !(still0 && still1);

   always_comb begin
      ref_horizontal_in = ref_horizontal_ff;
      ref_vertical_in   = ref_vertical_ff;
      if (kept) begin
         ref_horizontal_in[0] = item.first_x;
         ref_vertical_in[0]   = item.first_y;
         if (two_hit) begin
            ref_horizontal_in[1] = item.second_x;
            ref_vertical_in[1]   = item.second_y;
         end
         if (release_hit) begin
            ref_horizontal_in[0] = '0;
            ref_vertical_in[0]   = '0;
            ref_horizontal_in[1] = '0;
            ref_vertical_in[1]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_horizontal_ff[0] <= '0;
         ref_horizontal_ff[1] <= '0;
         ref_vertical_ff[0]   <= '0;
         ref_vertical_ff[1]   <= '0;
      end else if (advance) begin
         ref_horizontal_ff <= ref_horizontal_in;
         ref_vertical_ff   <= ref_vertical_in;
      end
   end

   assign step_ext = {1'b0, cfg.pinch_step};

   always_comb begin
      result.report_kept  = kept;
      result.first_valid  = kept && ((one_hit && item.first_x == item.second_x
                                      && item.first_y == item.second_y)
                                     || two_hit || release_hit);
      result.second_valid = kept && two_hit;
      result.touch_level  = release_hit ? trdf_pkg::LVL_NONE : trdf_pkg::LVL_TOUCH;
      result.out_first_x  = item.first_x;
      result.out_first_y  = item.first_y;
      result.out_second_x = item.second_x;
      result.out_second_y = item.second_y;
      case (item.gesture_code)
         trdf_pkg::GS_OUT: result.pinch_amount = $signed(step_ext);
         trdf_pkg::GS_IN:  result.pinch_amount = -$signed(step_ext);
         default:          result.pinch_amount = '0;
      endcase
      result.ack_needed   = release_hit;
   end

endmodule

// ===== src/touch_report_dedup_filter.sv =====
// Touch report duplicate filter. Each item is latched into an input register,
// judged combinationally against the two stored finger references and placed
// in a result register; a new item is taken every cycle as long as the result
// side keeps up. The result is offered once the item has moved from the input
// register into the result register, which waits while an earlier result is
// still not taken. The references advance at the moment an item moves from
// the input register into the result register, so each item sees the
// references left by the one before it. Settings take effect on items that
// leave the input register after the write.
module touch_report_dedup_filter (
   input  logic                        clock,
   input  logic                        reset,
   trdf_req_if.sink                    req_chan,
   trdf_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [trdf_pkg::CSR_W-1:0]  csr_write_data
);

   trdf_pkg::cfg_type    cfg;
   trdf_pkg::item_type   s1_item_ff;
   trdf_pkg::item_type   s1_item_in;
   logic                 s1_valid_ff;
   trdf_pkg::result_type result_comb;
   trdf_pkg::result_type out_ff;
   logic                 out_valid_ff;
   logic                 advance;
   logic                 accept;

   trdf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   trdf_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (s1_item_ff),
      .advance (advance),
      .result  (result_comb)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_item_in.status_code  = req_chan.status_code;
   assign s1_item_in.first_x      = req_chan.first_x;
   assign s1_item_in.first_y      = req_chan.first_y;
   assign s1_item_in.second_x     = req_chan.second_x;
   assign s1_item_in.second_y     = req_chan.second_y;
   assign s1_item_in.gesture_code = req_chan.gesture_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= accept;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         out_ff <= result_comb;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.report_kept  = out_ff.report_kept;
   assign rsp_chan.first_valid  = out_ff.first_valid;
   assign rsp_chan.second_valid = out_ff.second_valid;
   assign rsp_chan.touch_level  = out_ff.touch_level;
   assign rsp_chan.out_first_x  = out_ff.out_first_x;
   assign rsp_chan.out_first_y  = out_ff.out_first_y;
   assign rsp_chan.out_second_x = out_ff.out_second_x;
   assign rsp_chan.out_second_y = out_ff.out_second_y;
   assign rsp_chan.pinch_amount = out_ff.pinch_amount;
   assign rsp_chan.ack_needed   = out_ff.ack_needed;

   a_suppressed_no_contact: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.report_kept) |-> (!out_ff.first_valid && !out_ff.second_valid))
      else $error("suppressed item reports a contact");

   a_release_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.ack_needed) |-> (out_ff.report_kept
                                             && out_ff.touch_level == trdf_pkg::LVL_NONE))
      else $error("release item not kept at level zero");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("stalled input stage lost its item");

   a_result_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item not offered");

endmodule

// ===== sim/touch_report_dedup_filter_tb.sv =====
module touch_report_dedup_filter_tb;
   import trdf_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 210;
   localparam int SETTLE_TICKS = 6;

   class dedup_scoreboard;
      coord_type         threshold;
      logic [STEP_W-1:0] step;
      coord_type         ref_x[2];
      coord_type         ref_y[2];
      result_type        pending_reports[$];
      int                errors;
      int                checked;
      int                noted;
      int                kept;
      int                releases;

      function new();
         threshold = THRESHOLD_RESET;
         step      = STEP_RESET;
         ref_x     = '{default: '0};
         ref_y     = '{default: '0};
         errors    = 0;
         checked   = 0;
         noted     = 0;
         kept      = 0;
         releases  = 0;
      endfunction

      function void set_register(logic idx, logic [CSR_W-1:0] data);
         if (idx == CSR_MOVE_THRESHOLD)
            threshold = data;
         else
            step = data[STEP_W-1:0];
      endfunction

      function coord_type span(coord_type a, coord_type b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void note_report(item_type it);
         result_type want;
         logic       is_release;
         logic       is_two;
         logic       first_still;
         logic       second_still;
         logic       pass;
         is_release   = (it.status_code == ST_RELEASE);
         is_two       = (it.status_code == ST_TWO);
         first_still  = !is_release && span(ref_x[0], it.first_x) < threshold &&
                        span(ref_y[0], it.first_y) < threshold;
         second_still = !is_two || (span(ref_x[1], it.second_x) < threshold &&
                                    span(ref_y[1], it.second_y) < threshold);
         pass         = !(first_still && second_still);
         if (pass) begin
            ref_x[0] = it.first_x;
            ref_y[0] = it.first_y;
            if (is_two) begin
               ref_x[1] = it.second_x;
               ref_y[1] = it.second_y;
            end
            if (is_release) begin
               ref_x = '{default: '0};
               ref_y = '{default: '0};
            end
         end
         want.report_kept  = pass;
         want.first_valid  = pass && ((it.status_code == ST_ONE && it.first_x == it.second_x &&
                                       it.first_y == it.second_y) || is_two || is_release);
         want.second_valid = pass && is_two;
         want.touch_level  = is_release ? LVL_NONE : LVL_TOUCH;
         want.out_first_x  = it.first_x;
         want.out_first_y  = it.first_y;
         want.out_second_x = it.second_x;
         want.out_second_y = it.second_y;
         if (it.gesture_code == GS_OUT)
            want.pinch_amount = {1'b0, step};
         else if (it.gesture_code == GS_IN)
            want.pinch_amount = -{1'b0, step};
         else
            want.pinch_amount = '0;
         want.ack_needed = is_release;
         pending_reports.push_back(want);
         noted++;
         if (pass) kept++;
         if (is_release) releases++;
      endfunction

      function void flag(string field, logic [15:0] want_v, logic [15:0] got_v);
         if (want_v !== got_v) begin
            errors++;
            if (errors <= 10)
               $display("result %0d: %s expected %h, got %h", checked, field, want_v, got_v);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result %0d arrived with no report pending", checked);
            checked++;
            return;
         end
         want = pending_reports.pop_front();
         flag("report_kept", want.report_kept, got.report_kept);
         flag("first_valid", want.first_valid, got.first_valid);
         flag("second_valid", want.second_valid, got.second_valid);
         flag("touch_level", want.touch_level, got.touch_level);
         flag("out_first_x", want.out_first_x, got.out_first_x);
         flag("out_first_y", want.out_first_y, got.out_first_y);
         flag("out_second_x", want.out_second_x, got.out_second_x);
         flag("out_second_y", want.out_second_y, got.out_second_y);
         flag("pinch_amount", want.pinch_amount, got.pinch_amount);
         flag("ack_needed", want.ack_needed, got.ack_needed);
         checked++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic                csr_index;
   logic [CSR_W-1:0]    csr_write_data;
   bit                  calm;
   int                  cycles;
   int                  settings_applied;
   dedup_scoreboard     sb;

   trdf_req_if req_bus ();
   trdf_rsp_if rsp_bus ();

   touch_report_dedup_filter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic item_type mk(logic [7:0] st, coord_type x1, coord_type y1,
                                   coord_type x2, coord_type y2, logic [7:0] gs);
      item_type it;
      it.status_code  = st;
      it.first_x      = x1;
      it.first_y      = y1;
      it.second_x     = x2;
      it.second_y     = y2;
      it.gesture_code = gs;
      return it;
   endfunction

   function automatic coord_type nudge(coord_type c, int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return coord_type'(v);
   endfunction

   // result side: check accepted items, stall at random
   initial begin
      result_type got;
      int         stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.report_kept  = rsp_bus.report_kept;
            got.first_valid  = rsp_bus.first_valid;
            got.second_valid = rsp_bus.second_valid;
            got.touch_level  = rsp_bus.touch_level;
            got.out_first_x  = rsp_bus.out_first_x;
            got.out_first_y  = rsp_bus.out_first_y;
            got.out_second_x = rsp_bus.out_second_x;
            got.out_second_y = rsp_bus.out_second_y;
            got.pinch_amount = rsp_bus.pinch_amount;
            got.ack_needed   = rsp_bus.ack_needed;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0 && pick_gap() > 0) begin
            stall_left = pick_gap();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_report(item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.status_code  <= it.status_code;
      req_bus.first_x      <= it.first_x;
      req_bus.first_y      <= it.first_y;
      req_bus.second_x     <= it.second_x;
      req_bus.second_y     <= it.second_y;
      req_bus.gesture_code <= it.gesture_code;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_report(it);
   endtask

   // drop valid and let every pending item come out
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic apply_setting(logic [CSR_W-1:0] thr, logic [CSR_W-1:0] step_data);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MOVE_THRESHOLD;
      csr_write_data <= thr;
      @(posedge clock);
      sb.set_register(CSR_MOVE_THRESHOLD, thr);
      csr_index      <= CSR_PINCH_STEP;
      csr_write_data <= step_data;
      @(posedge clock);
      sb.set_register(CSR_PINCH_STEP, step_data);
      csr_write_en <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   task automatic run_strokes(int count);
      int         sent;
      int         len;
      int         spread;
      int         thr;
      bit         two;
      coord_type  ax, ay, bx, by;
      logic [7:0] gs;
      logic [7:0] st;
      item_type   it;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0:       st = ST_RELEASE;
               1:       st = ST_ONE;
               2:       st = ST_TWO;
               default: st = 8'($urandom);
            endcase
            it = mk(st, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                    8'($urandom));
            send_report(it);
            sent++;
         end else begin
            two = 1'($urandom_range(0, 1));
            ax  = 10'($urandom);
            ay  = 10'($urandom);
            bx  = 10'($urandom);
            by  = 10'($urandom);
            thr = int'(sb.threshold);
            case ($urandom_range(0, 3))
               0:       spread = 0;
               1:       spread = (thr > 1) ? thr - 1 : 0;
               2:       spread = thr + 1;
               default: spread = 2 * thr + 8;
            endcase
            case ($urandom_range(0, 4))
               0:       gs = GS_OUT;
               1:       gs = GS_IN;
               2:       gs = 8'($urandom);
               default: gs = 8'h00;
            endcase
            len = $urandom_range(2, 12);
            for (int k = 0; k < len; k++) begin
               st = two ? ST_TWO : ST_ONE;
               if ($urandom_range(0, 15) == 0) st = two ? ST_ONE : ST_TWO;
               it = mk(st, nudge(ax, spread), nudge(ay, spread), nudge(bx, spread),
                       nudge(by, spread), gs);
               if (!two && $urandom_range(0, 1) == 1) begin
                  it.second_x = it.first_x;
                  it.second_y = it.first_y;
               end
               if ($urandom_range(0, 9) == 0) it.gesture_code = 8'($urandom);
               if ($urandom_range(0, 3) == 0) begin
                  ax = it.first_x;
                  ay = it.first_y;
               end
               send_report(it);
               sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
               it = mk(ST_RELEASE, nudge(ax, spread), nudge(ay, spread), nudge(bx, spread),
                       nudge(by, spread), gs);
               send_report(it);
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb               = new();
      calm             = 1'b0;
      settings_applied = 0;
      reset               <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.status_code  <= '0;
      req_bus.first_x      <= '0;
      req_bus.first_y      <= '0;
      req_bus.second_x     <= '0;
      req_bus.second_y     <= '0;
      req_bus.gesture_code <= '0;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_MOVE_THRESHOLD;
      csr_write_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_report(mk(ST_ONE, 10'd0, 10'd0, 10'd0, 10'd0, 8'h00));
      send_report(mk(ST_ONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, GS_OUT));
      send_report(mk(ST_ONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, GS_OUT));
      send_report(mk(ST_ONE, 10'd5, 10'd6, 10'd7, 10'd8, GS_IN));
      send_report(mk(ST_TWO, 10'd5, 10'd6, 10'd1023, 10'd0, 8'h00));
      send_report(mk(ST_TWO, 10'd5, 10'd6, 10'd1023, 10'd0, 8'h00));
      send_report(mk(ST_TWO, 10'd5, 10'd6, 10'd1023, 10'd1, 8'h47));
      send_report(mk(ST_RELEASE, 10'd5, 10'd6, 10'd1023, 10'd1, 8'h4a));
      send_report(mk(ST_RELEASE, 10'd0, 10'd0, 10'd0, 10'd0, GS_IN));
      send_report(mk(8'h00, 10'd0, 10'd0, 10'd0, 10'd0, 8'hff));
      send_report(mk(8'hff, 10'h2aa, 10'h155, 10'h155, 10'h2aa, 8'h00));
      send_report(mk(8'h83, 10'h2aa, 10'h155, 10'h155, 10'h2aa, 8'h00));
      send_report(mk(ST_ONE, 10'h155, 10'h2aa, 10'h155, 10'h2aa, GS_OUT));
      send_report(mk(ST_TWO, 10'h155, 10'h2aa, 10'd0, 10'd0, 8'h00));
      settle();
      apply_setting(10'd0, 10'd127);
      send_report(mk(ST_ONE, 10'd0, 10'd0, 10'd0, 10'd0, GS_IN));
      send_report(mk(ST_ONE, 10'd0, 10'd0, 10'd0, 10'd0, GS_OUT));
      settle();
      apply_setting(10'd1023, 10'd0);
      send_report(mk(ST_TWO, 10'd1023, 10'd1023, 10'd1023, 10'd1023, GS_IN));
      send_report(mk(ST_TWO, 10'd1, 10'd1022, 10'd1022, 10'd1, GS_OUT));
      send_report(mk(ST_RELEASE, 10'd1, 10'd1, 10'd1, 10'd1, 8'h00));
      send_report(mk(ST_ONE, 10'd1022, 10'd0, 10'd1022, 10'd0, 8'h00));

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: apply_setting(10'd3, 10'd10);
            1: apply_setting(10'd0, 10'd127);
            2: apply_setting(10'd1023, 10'd0);
            3: apply_setting(10'd1, 10'($urandom));
            4: apply_setting(10'($urandom_range(2, 64)), 10'($urandom));
            default: apply_setting(10'($urandom_range(64, 400)), 10'($urandom));
         endcase
         calm = (p == 1);
         run_strokes(PHASE_ITEMS);
      end

      settle();
      $display("Sent %0d reports under %0d register settings: %0d kept, %0d suppressed, %0d releases",
               sb.noted, settings_applied, sb.kept, sb.noted - sb.kept, sb.releases);
      $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/trdf_pkg.sv
src/trdf_channels.sv
src/trdf_csr.sv
src/trdf_filter.sv
src/touch_report_dedup_filter.sv
sim/touch_report_dedup_filter_tb.sv
